### hw/rtl/gtgi_pkg.sv
// ============================================================================
// gtgi_pkg : gated trapezoid gyro integrator package
// Widths, derived stream widths and the reset constant shared by the block.
// ============================================================================
package gtgi_pkg;

   // Field widths
   localparam int TIME_WIDTH  = 64;
   localparam int RATE_WIDTH  = 24;
   localparam int SUM_WIDTH   = 56;
   localparam int GAP_WIDTH   = 20;
   localparam int COUNT_WIDTH = 32;
   localparam int AXES        = 6;

   // Arithmetic widths: rate pair sum, product of sum and dt, halved product
   localparam int RSUM_WIDTH = RATE_WIDTH + 1;
   localparam int PROD_WIDTH = RSUM_WIDTH + GAP_WIDTH + 1;
   localparam int HALF_WIDTH = PROD_WIDTH - 1;

   // Stream packing
   localparam int IN_DATA_BITS    = TIME_WIDTH + AXES * RATE_WIDTH;
   localparam int IN_TDATA_WIDTH  = ((IN_DATA_BITS + 7) / 8) * 8;
   localparam int OUT_DATA_BITS   = AXES * SUM_WIDTH + COUNT_WIDTH;
   localparam int OUT_TDATA_WIDTH = ((OUT_DATA_BITS + 7) / 8) * 8;

   // Reset value of the gap limit register
   localparam logic [GAP_WIDTH-1:0] GAP_RESET = GAP_WIDTH'(30000);

   typedef logic signed [RATE_WIDTH-1:0] rate_type;
   typedef logic signed [RSUM_WIDTH-1:0] rsum_type;
   typedef logic signed [SUM_WIDTH-1:0]  angle_type;

endpackage

### hw/rtl/gated_trapezoid_gyro_integrator_top.sv
// A result passes from its accepted sample through the input stage registers
// into the state and result registers, and rsp_tready can hold it there.
// Throughput: one sample per cycle unless rsp_tready stalls, set by the input
// stage and the single multiply and saturating add per axis in the result stage.
// Reset (synchronous, active high) clears the previous-sample state, the six
// angles and the step count, empties both stages and loads max gap 30000 us.
// ============================================================================
// gated_trapezoid_gyro_integrator_top : trapezoid rate integrator
// Integrates raw and corrected three-axis rates over timestamp deltas that
// are positive and within the configured gap, with saturating accumulators.
// ============================================================================
module gated_trapezoid_gyro_integrator_top
   import gtgi_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // configuration: max_gap_us
   input  logic                       csr_wr_en,
   input  logic [GAP_WIDTH-1:0]       csr_wr_data,
   // sample stream
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // sample_time_us, raw_rate_x, raw_rate_y, raw_rate_z,
   // fed_rate_x, fed_rate_y, fed_rate_z
   input  logic [IN_TDATA_WIDTH-1:0]  req_tdata,
   // result stream
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // raw_angle_x, raw_angle_y, raw_angle_z,
   // fed_angle_x, fed_angle_y, fed_angle_z, step_count
   output logic [OUT_TDATA_WIDTH-1:0] rsp_tdata,
   // step_taken
   output logic [0:0]                 rsp_tuser
);

   // configuration register
   logic [GAP_WIDTH-1:0]   max_gap_ff;

   // last accepted sample, seen at the input side
   logic                   last_valid_ff;
   logic [TIME_WIDTH-1:0]  last_time_ff;
   rate_type               last_rate_ff [AXES];

   // input stage
   logic                   s1_valid_ff;
   logic                   s1_gate_ff;
   logic [GAP_WIDTH-1:0]   s1_dt_ff;
   rsum_type               s1_rsum_ff [AXES];

   // integrator state and result stage
   angle_type              angle_ff [AXES];
   angle_type              angle_in [AXES];
   logic [COUNT_WIDTH-1:0] count_ff;
   logic                   rsp_valid_ff;
   logic                   taken_ff;

   // input decode and gating
   logic                   req_fire;
   logic                   s1_move;
   logic [TIME_WIDTH-1:0]  now;
   rate_type               cur_rate [AXES];
   logic [TIME_WIDTH-1:0]  dt_full;
   logic                   gate_in;

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      now = req_tdata[TIME_WIDTH-1:0];
      for (int i = 0; i < AXES; i++) begin
         cur_rate[i] = req_tdata[TIME_WIDTH + i*RATE_WIDTH +: RATE_WIDTH];
      end
      dt_full = now - last_time_ff;
      gate_in = last_valid_ff && (now > last_time_ff)
                && (dt_full <= {{(TIME_WIDTH-GAP_WIDTH){1'b0}}, max_gap_ff});
   end

   // gap limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff <= GAP_RESET;
      end else if (csr_wr_en) begin
         max_gap_ff <= csr_wr_data;
      end
   end

   // previous sample tracking and input stage load
   always_ff @(posedge clock) begin
      if (reset) begin
         last_valid_ff <= 1'b0;
         last_time_ff  <= '0;
         for (int i = 0; i < AXES; i++) begin
            last_rate_ff[i] <= '0;
         end
      end else if (req_fire) begin
         last_valid_ff <= 1'b1;
         last_time_ff  <= now;
         for (int i = 0; i < AXES; i++) begin
            last_rate_ff[i] <= cur_rate[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_gate_ff <= gate_in;
         s1_dt_ff   <= dt_full[GAP_WIDTH-1:0];
         for (int i = 0; i < AXES; i++) begin
            s1_rsum_ff[i] <= RSUM_WIDTH'(cur_rate[i]) + RSUM_WIDTH'(last_rate_ff[i]);
         end
      end
   end

   // trapezoid increment and saturating accumulate, one per axis
   always_comb begin
      logic signed [PROD_WIDTH-1:0]  prod;
      logic signed [PROD_WIDTH-1:0]  dt_ext;
      logic signed [PROD_WIDTH-1:0]  rsum_ext;
      logic signed [HALF_WIDTH-1:0]  half;
      logic signed [SUM_WIDTH:0]     wide;
      for (int i = 0; i < AXES; i++) begin
         dt_ext   = {{(PROD_WIDTH-GAP_WIDTH){1'b0}}, s1_dt_ff};
         rsum_ext = {{(PROD_WIDTH-RSUM_WIDTH){s1_rsum_ff[i][RSUM_WIDTH-1]}}, s1_rsum_ff[i]};
         prod     = rsum_ext * dt_ext;
         // arithmetic shift: rounds toward minus infinity
         half     = prod[PROD_WIDTH-1:1];
         wide     = {angle_ff[i][SUM_WIDTH-1], angle_ff[i]}
                    + {{(SUM_WIDTH+1-HALF_WIDTH){half[HALF_WIDTH-1]}}, half};
         if (wide[SUM_WIDTH] != wide[SUM_WIDTH-1]) begin
            angle_in[i] = wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                          : {1'b0, {(SUM_WIDTH-1){1'b1}}};
         end else begin
            angle_in[i] = wide[SUM_WIDTH-1:0];
         end
      end
   end

   // integrator state update, which also forms the result
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < AXES; i++) begin
            angle_ff[i] <= '0;
         end
      end else if (s1_move && s1_gate_ff) begin
         if (count_ff != {COUNT_WIDTH{1'b1}}) begin
            count_ff <= count_ff + COUNT_WIDTH'(1);
         end
         for (int i = 0; i < AXES; i++) begin
            angle_ff[i] <= angle_in[i];
         end
      end
   end

   // result valid and step flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         taken_ff     <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
         taken_ff     <= s1_gate_ff;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result packing straight from the state, which holds while a result waits
   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < AXES; i++) begin
         rsp_tdata[i*SUM_WIDTH +: SUM_WIDTH] = angle_ff[i];
      end
      rsp_tdata[AXES*SUM_WIDTH +: COUNT_WIDTH] = count_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = taken_ff;

   // a waiting result must not see its count or its first and last angles move
   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(count_ff) && $stable(angle_ff[0])
                                       && $stable(angle_ff[AXES-1])))
      else $error("state changed under a stalled result");

   // count moves by one, or holds at its maximum, only on a gated step
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (s1_move && s1_gate_ff) |=> (count_ff == $past(count_ff) + COUNT_WIDTH'(1)
                                   || $past(count_ff) == {COUNT_WIDTH{1'b1}}))
      else $error("step count did not advance");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !(s1_move && s1_gate_ff) |=> $stable(count_ff))
      else $error("step count moved without a step");

   // a step flag on a new result matches a gated step
   a_taken_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] && $past(s1_move)) |-> $past(s1_gate_ff))
      else $error("step flag without a gated step");

endmodule
